// ===== hdl/scafifo_pkg.sv =====
package scafifo_pkg;

  localparam int unsigned MAP_LEN = 84;
  localparam int unsigned CHAR_W  = 7;

  localparam logic OP_SCAN = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
  localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
  localparam logic [7:0] SC_CAPS_MAKE    = 8'h3A;
  localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;

  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 7'h7A;
  localparam logic [CHAR_W-1:0] CASE_OFFSET  = 7'h20;

  typedef struct packed {
    logic       opcode;
    logic [7:0] scan_byte;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] read_char;
    logic              char_valid;
    logic              key_available;
  } out_item_t;

  typedef struct packed {
    logic popped;
    logic avail;
  } ring_status_t;

  localparam logic [CHAR_W-1:0] PLAIN_MAP [MAP_LEN] = '{
    7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h37,
    7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31,
    7'h32, 7'h33, 7'h30, 7'h2E
  };

  localparam logic [CHAR_W-1:0] SHIFTED_MAP [MAP_LEN] = '{
    7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
    7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h37,
    7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31,
    7'h32, 7'h33, 7'h30, 7'h2E
  };

endpackage

// ===== hdl/scafifo_keymap.sv =====
module scafifo_keymap (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             scan_en,
  input  logic [7:0]                       scan_byte,
  output logic [scafifo_pkg::CHAR_W-1:0]   ch,
  output logic                             ch_ok
);

  logic       shift_r, shift_nxt;
  logic       caps_r, caps_nxt;
  logic       in_map;
  logic [6:0] idx;
  logic [scafifo_pkg::CHAR_W-1:0] plain_ch;
  logic [scafifo_pkg::CHAR_W-1:0] shift_ch;
  logic [scafifo_pkg::CHAR_W-1:0] sel_ch;

  assign in_map   = (scan_byte < 8'(scafifo_pkg::MAP_LEN));
  assign idx      = in_map ? scan_byte[6:0] : 7'd0;
  assign plain_ch = scafifo_pkg::PLAIN_MAP[idx];
  assign shift_ch = scafifo_pkg::SHIFTED_MAP[idx];

  always_comb begin
    if (shift_r) begin
      sel_ch = shift_ch;
    end else if (caps_r && plain_ch >= scafifo_pkg::CHAR_LOWER_A &&
                 plain_ch <= scafifo_pkg::CHAR_LOWER_Z) begin
      sel_ch = plain_ch - scafifo_pkg::CASE_OFFSET;
    end else begin
      sel_ch = plain_ch;
    end
  end

  assign ch    = sel_ch;
  assign ch_ok = scan_en && in_map && (sel_ch != '0);

  always_comb begin
    shift_nxt = shift_r;
    caps_nxt  = caps_r;
    if (scan_en) begin
      if (scan_byte == scafifo_pkg::SC_LSHIFT_MAKE ||
          scan_byte == scafifo_pkg::SC_RSHIFT_MAKE) begin
        shift_nxt = 1'b1;
      end else if (scan_byte == scafifo_pkg::SC_CAPS_MAKE) begin
        caps_nxt = !caps_r;
      end else if (scan_byte == scafifo_pkg::SC_LSHIFT_BREAK ||
                   scan_byte == scafifo_pkg::SC_RSHIFT_BREAK) begin
        shift_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= 1'b0;
      caps_r  <= 1'b0;
    end else begin
      shift_r <= shift_nxt;
      caps_r  <= caps_nxt;
    end
  end

endmodule

// ===== hdl/scafifo_ring.sv =====
module scafifo_ring #(
  parameter int unsigned FIFO_DEPTH = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  input  logic [scafifo_pkg::CHAR_W-1:0]  push_data,
  input  logic                            pop_req,
  output logic [scafifo_pkg::CHAR_W-1:0]  rdata,
  output scafifo_pkg::ring_status_t       status
);

  localparam int unsigned AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam logic [AW-1:0] LAST = AW'(FIFO_DEPTH - 1);

  logic [scafifo_pkg::CHAR_W-1:0] mem [FIFO_DEPTH];
  logic [scafifo_pkg::CHAR_W-1:0] rdata_r;
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [AW-1:0] head_inc, tail_inc;
  logic          empty, full, do_push, do_pop;

  assign head_inc = (head_r == LAST) ? '0 : head_r + AW'(1);
  assign tail_inc = (tail_r == LAST) ? '0 : tail_r + AW'(1);
  assign empty    = (head_r == tail_r);
  assign full     = (tail_inc == head_r);
  assign do_push  = push && !full;
  assign do_pop   = pop_req && !empty;

  assign head_nxt = do_pop ? head_inc : head_r;
  assign tail_nxt = do_push ? tail_inc : tail_r;

  assign status.popped = do_pop;
  assign status.avail  = (head_nxt != tail_nxt);
  assign rdata         = rdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[tail_r] <= push_data;
    end
    if (do_pop) begin
      rdata_r <= mem[head_r];
    end
  end

endmodule

// ===== hdl/scancode_to_ascii_fifo.sv =====
// PS/2 set-1 scancode decoder with a character queue.
// Input channel (in_valid/in_ready/in_data): each item is either a scancode
// byte (opcode scan) or a read request (opcode read). Shift and caps lock
// state is tracked from the scancodes; mapped characters are queued in a
// ring memory of FIFO_DEPTH slots holding up to FIFO_DEPTH-1 characters,
// and new characters are dropped when it is full.
// Output channel (out_valid/out_ready/out_data): exactly one item per input
// item, in order. A read returns the oldest character with char_valid set,
// or zero when the queue is empty; key_available shows the queue after the
// item.
// out_valid is registered and rises in the cycle after acceptance, and one item is taken
// every cycle while out_ready is high; the single-port ring memory takes one
// write or one registered read per item.
// Reset clears the queue and the shift and caps lock state; the memory is
// not cleared and needs no clearing pass.
// When the receiver stalls, the pending item is held and in_ready drops
// until it is taken.
module scancode_to_ascii_fifo #(
  parameter int unsigned FIFO_DEPTH = 256
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  scafifo_pkg::in_item_t  in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output scafifo_pkg::out_item_t out_data
);

  logic                           accept;
  logic                           scan_en;
  logic                           pop_req;
  logic [scafifo_pkg::CHAR_W-1:0] ch;
  logic                           ch_ok;
  logic [scafifo_pkg::CHAR_W-1:0] rdata;
  scafifo_pkg::ring_status_t      status;

  logic out_valid_r, out_valid_nxt;
  logic popped_r;
  logic avail_r;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign scan_en  = accept && (in_data.opcode == scafifo_pkg::OP_SCAN);
  assign pop_req  = accept && (in_data.opcode == scafifo_pkg::OP_READ);

  scafifo_keymap u_keymap (
    .clk       (clk),
    .rst_n     (rst_n),
    .scan_en   (scan_en),
    .scan_byte (in_data.scan_byte),
    .ch        (ch),
    .ch_ok     (ch_ok)
  );

  scafifo_ring #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (ch_ok),
    .push_data (ch),
    .pop_req   (pop_req),
    .rdata     (rdata),
    .status    (status)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      popped_r <= status.popped;
      avail_r  <= status.avail;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_data.read_char     = popped_r ? rdata : '0;
  assign out_data.char_valid    = popped_r;
  assign out_data.key_available = avail_r;

endmodule

// ===== test/scancode_to_ascii_fifo_test.sv =====
module scancode_to_ascii_fifo_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_ITEMS        = 1750;
  localparam int QUIET_ITEMS    = 150;
  localparam int FILL_ITEMS     = 562;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;
  localparam int LONG_STALL     = 60;

  localparam logic [6:0] US_PLAIN [scafifo_pkg::MAP_LEN] = '{
    7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h37,
    7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31,
    7'h32, 7'h33, 7'h30, 7'h2E
  };

  localparam logic [6:0] US_SHIFTED [scafifo_pkg::MAP_LEN] = '{
    7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
    7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h37,
    7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31,
    7'h32, 7'h33, 7'h30, 7'h2E
  };

  typedef struct {
    scafifo_pkg::in_item_t item;
    bit                    drain_first;
    bit                    quiet;
  } key_item_t;

  logic                   clk;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  scafifo_pkg::in_item_t  in_data   = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  scafifo_pkg::out_item_t out_data;

  key_item_t              key_items[$];
  scafifo_pkg::out_item_t due_outputs[$];
  key_item_t              next_key;
  scafifo_pkg::out_item_t want;

  logic [6:0] ring [256];
  logic [7:0] ring_head = '0;
  logic [7:0] ring_tail = '0;
  bit         shift_on  = 1'b0;
  bit         caps_on   = 1'b0;

  bit gen_quiet;
  bit calm = 1'b0;
  int gap_left;
  int stall_left;
  bit long_stall_done;
  int results_seen;
  int mismatches;
  int idle_cycles;
  int fills_done;

  scancode_to_ascii_fifo i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic scafifo_pkg::out_item_t decode_item(scafifo_pkg::in_item_t it);
    scafifo_pkg::out_item_t r;
    logic [6:0]             ch;
    logic [7:0]             tail_next;
    r = '0;
    if (it.opcode == scafifo_pkg::OP_SCAN) begin
      if (it.scan_byte == scafifo_pkg::SC_LSHIFT_MAKE ||
          it.scan_byte == scafifo_pkg::SC_RSHIFT_MAKE) begin
        shift_on = 1'b1;
      end else if (it.scan_byte == scafifo_pkg::SC_CAPS_MAKE) begin
        caps_on = ~caps_on;
      end else if (it.scan_byte == scafifo_pkg::SC_LSHIFT_BREAK ||
                   it.scan_byte == scafifo_pkg::SC_RSHIFT_BREAK) begin
        shift_on = 1'b0;
      end else if (!it.scan_byte[7] && it.scan_byte < scafifo_pkg::MAP_LEN) begin
        ch = shift_on ? US_SHIFTED[it.scan_byte[6:0]] : US_PLAIN[it.scan_byte[6:0]];
        if (!shift_on && caps_on && ch >= scafifo_pkg::CHAR_LOWER_A &&
            ch <= scafifo_pkg::CHAR_LOWER_Z) begin
          ch = ch - scafifo_pkg::CASE_OFFSET;
        end
        tail_next = ring_tail + 8'd1;
        if (ch != '0 && tail_next != ring_head) begin
          ring[ring_tail] = ch;
          ring_tail = tail_next;
        end
      end
    end else if (ring_head != ring_tail) begin
      r.read_char  = ring[ring_head];
      r.char_valid = 1'b1;
      ring_head    = ring_head + 8'd1;
    end
    r.key_available = (ring_head != ring_tail);
    return r;
  endfunction

  function automatic void flag_error(string what, scafifo_pkg::out_item_t exp_item,
                                     scafifo_pkg::out_item_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t %s: expected char %h valid %b avail %b, got char %h valid %b avail %b",
               $realtime, what, exp_item.read_char, exp_item.char_valid,
               exp_item.key_available, got.read_char, got.char_valid, got.key_available);
    end
  endfunction

  function automatic void add_item(logic op, logic [7:0] code, bit drain = 1'b0);
    key_item_t k;
    k.item.opcode    = op;
    k.item.scan_byte = code;
    k.drain_first    = drain;
    k.quiet          = gen_quiet;
    key_items.push_back(k);
  endfunction

  // typing with shift held and released around keys, caps toggles, reads and high scan bytes
  function automatic void type_burst(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 19);
      if (r < 2) begin
        add_item(scafifo_pkg::OP_SCAN,
                 r[0] ? scafifo_pkg::SC_LSHIFT_MAKE : scafifo_pkg::SC_RSHIFT_MAKE);
      end else if (r < 4) begin
        add_item(scafifo_pkg::OP_SCAN,
                 r[0] ? scafifo_pkg::SC_LSHIFT_BREAK : scafifo_pkg::SC_RSHIFT_BREAK);
      end else if (r == 4) begin
        add_item(scafifo_pkg::OP_SCAN, scafifo_pkg::SC_CAPS_MAKE);
      end else if (r < 10) begin
        add_item(scafifo_pkg::OP_READ, 8'($urandom_range(0, 255)));
      end else if (r == 10) begin
        add_item(scafifo_pkg::OP_SCAN, 8'($urandom_range(8'h80, 8'hFF)));
      end else begin
        add_item(scafifo_pkg::OP_SCAN, 8'($urandom_range(0, scafifo_pkg::MAP_LEN - 1)));
      end
    end
  endfunction

  // overfill the ring, then read past empty
  function automatic void fill_and_empty();
    add_item(scafifo_pkg::OP_SCAN, 8'($urandom_range(8'h10, 8'h19)), 1'b1);
    repeat (299) add_item(scafifo_pkg::OP_SCAN, 8'($urandom_range(8'h10, 8'h19)));
    repeat (262) add_item(scafifo_pkg::OP_READ, 8'($urandom_range(0, 255)));
    fills_done++;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        due_outputs.push_back(decode_item(in_data));
      end
      if (!(in_valid && !in_ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (key_items.size() == 0) begin
          in_valid <= 1'b0;
        end else if (key_items[0].drain_first && due_outputs.size() != 0) begin
          in_valid <= 1'b0;
        end else if (!key_items[0].quiet && $urandom_range(0, 9) == 0) begin
          gap_left = $urandom_range(0, 10);
          in_valid <= 1'b0;
        end else begin
          next_key = key_items.pop_front();
          in_valid <= 1'b1;
          in_data  <= next_key.item;
          if (next_key.quiet) begin
            calm <= 1'b1;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (due_outputs.size() == 0) begin
          flag_error("result with none due", '0, out_data);
        end else begin
          want = due_outputs.pop_front();
          if (out_data.read_char !== want.read_char || out_data.char_valid !== want.char_valid
              || out_data.key_available !== want.key_available) begin
            flag_error("mismatch", want, out_data);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!long_stall_done && results_seen >= 300) begin
        long_stall_done = 1'b1;
        stall_left = LONG_STALL - 1;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 10);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    add_item(scafifo_pkg::OP_READ, 8'hFF);
    add_item(scafifo_pkg::OP_SCAN, 8'h00);
    add_item(scafifo_pkg::OP_SCAN, 8'hFF);
    add_item(scafifo_pkg::OP_SCAN, 8'h80);
    add_item(scafifo_pkg::OP_SCAN, 8'h7F);
    add_item(scafifo_pkg::OP_SCAN, 8'h54);
    add_item(scafifo_pkg::OP_SCAN, 8'h53);
    add_item(scafifo_pkg::OP_SCAN, 8'h10);
    add_item(scafifo_pkg::OP_SCAN, scafifo_pkg::SC_CAPS_MAKE);
    add_item(scafifo_pkg::OP_SCAN, 8'h1E);
    add_item(scafifo_pkg::OP_SCAN, 8'h02);
    add_item(scafifo_pkg::OP_SCAN, scafifo_pkg::SC_LSHIFT_MAKE);
    add_item(scafifo_pkg::OP_SCAN, 8'h1E);
    add_item(scafifo_pkg::OP_SCAN, 8'h02);
    add_item(scafifo_pkg::OP_SCAN, scafifo_pkg::SC_RSHIFT_MAKE);
    add_item(scafifo_pkg::OP_SCAN, scafifo_pkg::SC_LSHIFT_BREAK);
    add_item(scafifo_pkg::OP_SCAN, 8'h1E);
    add_item(scafifo_pkg::OP_SCAN, scafifo_pkg::SC_CAPS_MAKE);
    add_item(scafifo_pkg::OP_SCAN, scafifo_pkg::SC_RSHIFT_MAKE);
    add_item(scafifo_pkg::OP_SCAN, 8'h35);
    add_item(scafifo_pkg::OP_SCAN, scafifo_pkg::SC_RSHIFT_BREAK);
    add_item(scafifo_pkg::OP_SCAN, 8'h1D);
    add_item(scafifo_pkg::OP_READ, scafifo_pkg::SC_LSHIFT_MAKE);
    repeat (7) add_item(scafifo_pkg::OP_READ, 8'h00);

    add_item(scafifo_pkg::OP_SCAN, 8'h39, 1'b1);
    while (key_items.size() < N_ITEMS - QUIET_ITEMS) begin
      if (fills_done == 0 && key_items.size() > 500) begin
        fill_and_empty();
      end else begin
        case ($urandom_range(0, 9))
          0: begin
            repeat (20) add_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
          end
          1: begin
            if (fills_done < 2 && key_items.size() > 900 &&
                key_items.size() + FILL_ITEMS < N_ITEMS - QUIET_ITEMS) begin
              fill_and_empty();
            end
          end
          default: type_burst(30);
        endcase
      end
    end
    gen_quiet = 1'b1;
    type_burst(QUIET_ITEMS);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    while (key_items.size() != 0 || in_valid || due_outputs.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
